### design/bdd_pkg.sv
// ----------------------------------------------------------------------------
// bdd_pkg
// Shared types, constants and helpers for the backward-difference divergence
// block.
// ----------------------------------------------------------------------------
package bdd_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 11;

    // Width used to compare frame positions against the programmed size.
    // It holds any supported maximum size.
    localparam int SIZE_BITS = 14;

    localparam logic [CFG_DATA_BITS-1:0] RESET_SIZE = CFG_DATA_BITS'(1024);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Index of the last column and last row after clamping the size.
    typedef struct packed {
        logic [SIZE_BITS-1:0] last_col;
        logic [SIZE_BITS-1:0] last_row;
    } frame_limits_t;

    // Border flags of one pixel.
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
    } pos_flags_t;

    // Clamps a programmed size to 2..max_size and returns the last index.
    function automatic logic [SIZE_BITS-1:0] last_index(
        input logic [CFG_DATA_BITS-1:0] size,
        input logic [SIZE_BITS-1:0]     max_size
    );
        logic [SIZE_BITS-1:0] s;
        s = SIZE_BITS'(size);
        if (s < SIZE_BITS'(2))
            return SIZE_BITS'(1);
        else if (s > max_size)
            return max_size - SIZE_BITS'(1);
        else
            return s - SIZE_BITS'(1);
    endfunction

endpackage

### design/bdd_ifs.sv
// ----------------------------------------------------------------------------
// bdd_ifs
// Valid/ready channel interfaces for the vector field input, the divergence
// output and the configuration writes.
// ----------------------------------------------------------------------------
interface bdd_in_if #(
    parameter int SAMPLE_BITS = bdd_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] horizontal_component;
    logic signed [SAMPLE_BITS-1:0] vertical_component;

    modport source (output valid, output horizontal_component,
                    output vertical_component, input ready);
    modport sink   (input valid, input horizontal_component,
                    input vertical_component, output ready);
endinterface

interface bdd_out_if #(
    parameter int SAMPLE_BITS = bdd_pkg::DEF_SAMPLE_BITS
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS+1:0]   divergence_value;
    logic                            frame_end;

    modport source (output valid, output divergence_value, output frame_end,
                    input ready);
    modport sink   (input valid, input divergence_value, input frame_end,
                    output ready);
endinterface

interface bdd_cfg_if;
    import bdd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/bdd_cfg.sv
// ----------------------------------------------------------------------------
// bdd_cfg
// Image size registers with clamping to the supported range.
// ----------------------------------------------------------------------------
module bdd_cfg #(
    parameter int MAX_WIDTH  = bdd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bdd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    bdd_cfg_if.sink                cfg_ch,
    output bdd_pkg::frame_limits_t limits
);
    import bdd_pkg::*;

    localparam logic [SIZE_BITS-1:0] MAX_W = SIZE_BITS'(MAX_WIDTH);
    localparam logic [SIZE_BITS-1:0] MAX_H = SIZE_BITS'(MAX_HEIGHT);

    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;

    // Writes are always taken.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_SIZE;
            height_reg <= RESET_SIZE;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_reg_t'(cfg_ch.index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_ch.data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_ch.data;
            endcase
        end
    end

    assign limits.last_col = last_index(width_reg, MAX_W);
    assign limits.last_row = last_index(height_reg, MAX_H);

endmodule

### design/bdd_row_store.sv
// ----------------------------------------------------------------------------
// bdd_row_store
// One-row line memory with a registered read; a read and a write to the same
// address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module bdd_row_store #(
    parameter int DEPTH     = bdd_pkg::DEF_MAX_WIDTH,
    parameter int DATA_BITS = bdd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [DATA_BITS-1:0]       wdata,
    output logic [DATA_BITS-1:0]       rdata
);
    import bdd_pkg::*;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/backward_difference_divergence.sv
// ----------------------------------------------------------------------------
// backward_difference_divergence
// Streaming divergence of a 2-D vector field by backward differences.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock in raster order, while the output side
// is not stalled, and returns one divergence item per pixel, in the same
// order, registered in the first stage and then in the output register. The
// sustained rate is one pixel per cycle when the output is not stalled; it is
// set by the single row store, which is read and written at the pixel's
// column in the cycle the pixel is accepted. Pixel position is tracked by
// internal column and row counters that wrap at the programmed image size,
// so the first pixel after reset or after a completed frame is the top-left
// corner. Sizes below 2 act as 2 and sizes above the maximum act as the
// maximum. The row store needs no initialization: in a frame of fixed size
// every entry is written on the first row before it is read on the second.
// ----------------------------------------------------------------------------
module backward_difference_divergence #(
    parameter int MAX_WIDTH   = bdd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bdd_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = bdd_pkg::DEF_SAMPLE_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    bdd_cfg_if.sink  cfg_ch,
    bdd_in_if.sink   in_ch,
    bdd_out_if.source out_ch
);
    import bdd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SB = SAMPLE_BITS;

    frame_limits_t limits;

    // Frame position and the previous pixel's horizontal component.
    logic [AW-1:0]        col_reg;
    logic [AW-1:0]        col_next;
    logic [RW-1:0]        row_reg;
    logic [RW-1:0]        row_next;
    logic [SB-1:0]        left_reg;
    pos_flags_t           flags;

    // First stage: pixel waiting for its row store read.
    logic                 s1_valid_reg;
    logic [SB-1:0]        s1_v1_reg;
    logic [SB-1:0]        s1_v2_reg;
    logic [SB-1:0]        s1_left_reg;
    pos_flags_t           s1_flags_reg;
    logic [SB-1:0]        up_data;

    // Output register.
    logic                 out_valid_reg;
    logic signed [SB+1:0] out_div_reg;
    logic                 out_end_reg;

    logic                 in_fire;
    logic                 s1_adv;
    logic signed [SB:0]   v1_ext;
    logic signed [SB:0]   v2_ext;
    logic signed [SB:0]   left_ext;
    logic signed [SB:0]   up_ext;
    logic signed [SB:0]   h_term;
    logic signed [SB:0]   v_term;
    logic signed [SB+1:0] div_next;

    bdd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .limits (limits)
    );

    // The vertical component of this pixel replaces the one from the row
    // above, which is read out in the same cycle.
    bdd_row_store #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (SB)
    ) u_row_store (
        .clk   (clk),
        .en    (in_fire),
        .addr  (col_reg),
        .wdata (in_ch.vertical_component),
        .rdata (up_data)
    );

    // The output register advances whenever it is empty or being drained;
    // the first stage moves along with it, so a pixel is taken whenever the
    // first stage is empty or about to move on.
    assign s1_adv      = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Border flags. A column or row at or past the programmed last index is
    // treated as the last one, which covers a size reduced mid-frame.
    assign flags.first_col = (col_reg == '0);
    assign flags.last_col  = (SIZE_BITS'(col_reg) >= limits.last_col);
    assign flags.first_row = (row_reg == '0);
    assign flags.last_row  = (SIZE_BITS'(row_reg) >= limits.last_row);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (flags.last_col)
        begin
            col_next = '0;
            if (flags.last_row)
                row_next = '0;
            else
                row_next = row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= in_ch.horizontal_component;
        end
    end

    // First stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_v1_reg    <= in_ch.horizontal_component;
            s1_v2_reg    <= in_ch.vertical_component;
            s1_left_reg  <= left_reg;
            s1_flags_reg <= flags;
        end
    end

    // Divergence: horizontal and vertical backward differences with the
    // adjoint-of-gradient rules on the border.
    assign v1_ext   = $signed({s1_v1_reg[SB-1], s1_v1_reg});
    assign v2_ext   = $signed({s1_v2_reg[SB-1], s1_v2_reg});
    assign left_ext = $signed({s1_left_reg[SB-1], s1_left_reg});
    assign up_ext   = $signed({up_data[SB-1], up_data});

    always_comb
    begin
        priority if (s1_flags_reg.first_col)
            h_term = v1_ext;
        else if (s1_flags_reg.last_col)
            h_term = -left_ext;
        else
            h_term = v1_ext - left_ext;

        priority if (s1_flags_reg.first_row)
            v_term = v2_ext;
        else if (s1_flags_reg.last_row)
            v_term = -up_ext;
        else
            v_term = v2_ext - up_ext;

        div_next = $signed({h_term[SB], h_term}) + $signed({v_term[SB], v_term});
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_div_reg <= div_next;
            out_end_reg <= s1_flags_reg.last_col && s1_flags_reg.last_row;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.divergence_value = out_div_reg;
    assign out_ch.frame_end        = out_end_reg;

    // An accepted pixel always lands in the first stage.
    a_accept_fills_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg
    ) else $error("accepted pixel did not reach the first stage");

    // With at least two columns a pixel is never both first and last column.
    a_col_flags_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_flags_reg.first_col && s1_flags_reg.last_col)
    ) else $error("pixel flagged as first and last column");

    // The column counter wraps after the last column.
    a_col_wrap: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_fire && flags.last_col) |=> (col_reg == '0)
    ) else $error("column counter did not wrap");

    // Otherwise the column counter steps by one.
    a_col_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_fire && !flags.last_col) |=> (col_reg == $past(col_reg) + AW'(1))
    ) else $error("column counter did not advance");

endmodule
